@@ hw/rtl/vsc_pkg.sv @@
// Shared types, constants and lookup tables for the version string comparator.
package vsc_pkg;

  localparam int CHAR_W  = 21;
  localparam int ORDER_W = 22;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CH_NINE = CHAR_W'(57);

  // character classes
  localparam logic [1:0] CLS_OTHER = 2'd0;
  localparam logic [1:0] CLS_DIGIT = 2'd1;
  localparam logic [1:0] CLS_ZERO  = 2'd2;

  // scan automaton states, spaced by three so state + class is a table row
  localparam logic [3:0] ST_N = 4'h0;
  localparam logic [3:0] ST_I = 4'h3;
  localparam logic [3:0] ST_F = 4'h6;
  localparam logic [3:0] ST_Z = 4'h9;
  localparam logic [3:0] ST_ROWS = 4'd12;

  typedef enum logic [2:0] {
    PH_DONE = 3'b001,
    PH_SCAN = 3'b010,
    PH_LEN  = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    V_CMP,
    V_LEN,
    V_NEG,
    V_POS
  } verdict_t;

  typedef logic signed [ORDER_W-1:0] order_t;

  // one classified pair as it waits in the queue
  typedef struct packed {
    logic       first;
    logic [1:0] cls_a;
    logic [1:0] cls_b;
    logic       eq;
    logic       a_zero;
    order_t     diff;
  } q_item_t;

  function automatic logic [1:0] char_class(input logic [CHAR_W-1:0] c);
    logic dig;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    if (c == CH_ZERO) begin
      return CLS_ZERO;
    end else if (dig) begin
      return CLS_DIGIT;
    end
    return CLS_OTHER;
  endfunction

  function automatic logic [3:0] scan_next(input logic [3:0] st);
    case (st)
      4'd0:    return ST_N;
      4'd1:    return ST_I;
      4'd2:    return ST_Z;
      4'd3:    return ST_N;
      4'd4:    return ST_I;
      4'd5:    return ST_I;
      4'd6:    return ST_N;
      4'd7:    return ST_F;
      4'd8:    return ST_F;
      4'd9:    return ST_N;
      4'd10:   return ST_F;
      4'd11:   return ST_Z;
      default: return ST_N;
    endcase
  endfunction

  function automatic verdict_t verdict_kind(input logic [3:0] st, input logic [1:0] cls_b);
    case (st)
      4'd1:    return (cls_b == CLS_DIGIT) ? V_LEN : V_CMP;
      4'd3:    return (cls_b == CLS_OTHER) ? V_CMP : V_NEG;
      4'd4,
      4'd5:    return (cls_b == CLS_OTHER) ? V_POS : V_LEN;
      4'd9:    return (cls_b == CLS_OTHER) ? V_CMP : V_POS;
      4'd10,
      4'd11:   return (cls_b == CLS_OTHER) ? V_NEG : V_CMP;
      default: return V_CMP;
    endcase
  endfunction

endpackage

@@ hw/rtl/vsc_in_if.sv @@
// Input channel: one codepoint pair per beat.
interface vsc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        first;
  logic [vsc_pkg::CHAR_W-1:0]  char_a;
  logic [vsc_pkg::CHAR_W-1:0]  char_b;

  modport source (output valid, output first, output char_a, output char_b, input ready);
  modport sink   (input valid, input first, input char_a, input char_b, output ready);
endinterface

@@ hw/rtl/vsc_out_if.sv @@
// Result channel: one verdict per beat.
interface vsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [vsc_pkg::ORDER_W-1:0] order;

  modport source (output valid, output order, input ready);
  modport sink   (input valid, input order, output ready);
endinterface

@@ hw/rtl/version_string_compare.sv @@
// Top level: version-order comparison of two codepoint strings.
//
//  channel | dir | beat contents         | handshake
//  in_bus  | in  | first, char_a, char_b | valid/ready
//  out_bus | out | order                 | valid/ready
//
// One pair per cycle sustained; a pair is written into the queue, and
// its verdict appears in the output register the cycle after it is popped.
// The back-end state update (one table lookup) sets the rate.
// Reset (rst_n low, synchronous) empties the queue and drops any open compare.
// A held result stalls the back end; the four-entry queue then fills
// before in_bus.ready drops.
module version_string_compare (
  input  logic      clk,
  input  logic      rst_n,
  vsc_in_if.sink    in_bus,
  vsc_out_if.source out_bus
);
  import vsc_pkg::*;

  logic    push;
  logic    pop;
  logic    q_full;
  logic    q_valid;
  q_item_t push_item;
  q_item_t head_item;

  vsc_front u_front (
    .in_bus    (in_bus),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  vsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_full    (q_full),
    .q_valid   (q_valid),
    .head_item (head_item)
  );

  vsc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head_item (head_item),
    .pop       (pop),
    .out_bus   (out_bus)
  );
endmodule

@@ hw/rtl/vsc_front.sv @@
// Front end: takes input beats and classifies each codepoint pair.
module vsc_front (
  vsc_in_if.sink           in_bus,
  input  logic             q_full,
  output logic             push,
  output vsc_pkg::q_item_t push_item
);
  import vsc_pkg::*;

  assign in_bus.ready = !q_full;
  assign push         = in_bus.valid && !q_full;

  always_comb begin
    push_item.first  = in_bus.first;
    push_item.cls_a  = char_class(in_bus.char_a);
    push_item.cls_b  = char_class(in_bus.char_b);
    push_item.eq     = (in_bus.char_a == in_bus.char_b);
    push_item.a_zero = (in_bus.char_a == '0);
    push_item.diff   = order_t'({1'b0, in_bus.char_a}) - order_t'({1'b0, in_bus.char_b});
  end
endmodule

@@ hw/rtl/vsc_queue.sv @@
// Short FIFO of classified pairs between front and back end.
module vsc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  vsc_pkg::q_item_t push_item,
  input  logic             pop,
  output logic             q_full,
  output logic             q_valid,
  output vsc_pkg::q_item_t head_item
);
  import vsc_pkg::*;

  q_item_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r;
  logic [Q_AW-1:0]   rd_ptr_r;
  logic [Q_CW-1:0]   cnt_r;
  logic [Q_CW-1:0]   cnt_nxt;

  assign q_full    = (cnt_r == Q_CW'(Q_DEPTH));
  assign q_valid   = (cnt_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CW'(Q_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count lost a push");
endmodule

@@ hw/rtl/vsc_back.sv @@
// Back end: scan automaton, length phase and registered result.
module vsc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  vsc_pkg::q_item_t head_item,
  output logic             pop,
  vsc_out_if.source        out_bus
);
  import vsc_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [3:0] scan_r, scan_nxt;
  order_t     saved_r, saved_nxt;
  logic       out_valid_r;
  order_t     out_order_r;

  logic       emit;
  order_t     emit_val;
  logic       go_scan;
  logic [3:0] st;
  logic [3:0] base;
  logic       dig_a;
  logic       dig_b;

  assign pop           = q_valid && (!out_valid_r || out_bus.ready);
  assign out_bus.valid = out_valid_r;
  assign out_bus.order = out_order_r;

  assign dig_a = (head_item.cls_a != CLS_OTHER);
  assign dig_b = (head_item.cls_b != CLS_OTHER);
  assign base  = (scan_r < ST_ROWS) ? scan_r : ST_N;

  always_comb begin
    phase_nxt = phase_r;
    scan_nxt  = scan_r;
    saved_nxt = saved_r;
    emit      = 1'b0;
    emit_val  = '0;
    go_scan   = 1'b0;
    st        = ST_N;
    if (pop) begin
      if (head_item.first) begin
        go_scan = 1'b1;
        st      = {2'b00, head_item.cls_a};
      end else begin
        case (phase_r)
          PH_SCAN: begin
            go_scan = 1'b1;
            st      = base + {2'b00, head_item.cls_a};
          end
          PH_LEN: begin
            // digit runs keep going until one of them ends
            if (dig_a) begin
              if (!dig_b) begin
                emit     = 1'b1;
                emit_val = order_t'(1);
              end
            end else begin
              emit     = 1'b1;
              emit_val = dig_b ? order_t'(-1) : saved_r;
            end
          end
          default: ;
        endcase
      end

      if (go_scan) begin
        if (head_item.eq) begin
          if (head_item.a_zero) begin
            emit = 1'b1;
          end else begin
            scan_nxt  = scan_next(st);
            phase_nxt = PH_SCAN;
          end
        end else begin
          case (verdict_kind(st, head_item.cls_b))
            V_LEN: begin
              saved_nxt = head_item.diff;
              phase_nxt = PH_LEN;
            end
            V_NEG: begin
              emit     = 1'b1;
              emit_val = order_t'(-1);
            end
            V_POS: begin
              emit     = 1'b1;
              emit_val = order_t'(1);
            end
            default: begin
              emit     = 1'b1;
              emit_val = head_item.diff;
            end
          endcase
        end
      end

      if (emit) begin
        phase_nxt = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DONE;
      scan_r      <= ST_N;
      saved_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      scan_r  <= scan_nxt;
      saved_r <= saved_nxt;
      if (pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_order_r <= emit_val;
    end
  end

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && emit) |=> (phase_r == PH_DONE && out_valid_r))
    else $error("verdict did not close the comparison");

  a_scan_code: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_r == ST_N) || (scan_r == ST_I) || (scan_r == ST_F) || (scan_r == ST_Z))
    else $error("scan state off the automaton grid");

  a_len_saved: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LEN) |-> (saved_r != '0))
    else $error("length phase without a saved difference");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |-> !pop)
    else $error("back end popped over a held result");
endmodule
